// File: rtl/mqsb_pkg.sv
// Shared types and codes for the multi-queue shared buffer.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package mqsb_pkg;

  localparam int KIND_W   = 1;
  localparam int QID_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_ENQ = 1'b0;
  localparam logic [KIND_W-1:0] KIND_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_POP   = 4'b1000
  } state_t;

endpackage

// File: rtl/mqsb_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module mqsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/multi_queue_shared_buffer.sv
// Top level of the multi-queue shared buffer: control, free list and result register.
// Depends on mqsb_pkg and mqsb_ram (slot data, slot link and queue table stores).
//
//   Channel  Ports                                                Direction
//   in       in_valid, in_stall, in_kind, in_queue_id, in_value   request in
//   out      out_valid, out_stall, out_read_value, out_status,    result out
//            out_queue_empty, out_buffer_full
//
// An enqueue finishes in S_LOOK, once the registered read of the queue table is back; a
// dequeue goes on to S_POP for the read of the link and data stores at the queue head.
// After reset a clearing pass over all QUEUES entries empties the queue table; in_stall is
// high meanwhile. A request is taken only when the previous one has finished; a stalled
// result holds the final step until the result register frees up.
`timescale 1ns / 1ps

module multi_queue_shared_buffer #(
  parameter int ENTRIES    = 64,
  parameter int QUEUES     = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mqsb_pkg::KIND_W-1:0]          in_kind,
  input  logic [mqsb_pkg::QID_W-1:0]           in_queue_id,
  input  logic signed [mqsb_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mqsb_pkg::VALUE_W-1:0]  out_read_value,
  output logic [mqsb_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_queue_empty,
  output logic                                 out_buffer_full
);

  import mqsb_pkg::*;

  localparam int DW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int LW = $clog2(ENTRIES + 1);
  localparam int SW = $clog2(ENTRIES);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int QE = LW + SW;
  localparam logic [LW-1:0] LINK_NULL = LW'(ENTRIES);

  state_t              state_r, state_nxt;
  logic [QW-1:0]       clr_r, clr_nxt;
  logic [LW-1:0]       free_head_r, free_head_nxt;
  logic [LW-1:0]       fill_r, fill_nxt;
  logic [KIND_W-1:0]   kind_r;
  logic                qvalid_r;
  logic [QW-1:0]       qaddr_r;
  logic [DW-1:0]       value_r;

  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_read_value_r, out_read_value_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_queue_empty_r, out_queue_empty_nxt;
  logic                out_buffer_full_r, out_buffer_full_nxt;
  logic                load;

  logic                accept;
  logic                out_free;

  logic                qt_we;
  logic [QW-1:0]       qt_waddr, qt_raddr;
  logic [QE-1:0]       qt_wdata, qt_rdata;
  logic                lk_we;
  logic [SW-1:0]       lk_waddr, lk_raddr;
  logic [LW-1:0]       lk_wdata, lk_rdata;
  logic                dt_we;
  logic [SW-1:0]       dt_waddr, dt_raddr;
  logic [DW-1:0]       dt_wdata, dt_rdata;

  logic [LW-1:0]       q_head;
  logic [SW-1:0]       q_tail;
  logic                q_empty;
  logic                free_null;
  logic                fresh;
  logic [LW-1:0]       next_free;
  logic [LW-1:0]       new_head;

  mqsb_ram #(.WIDTH(QE), .DEPTH(QUEUES)) u_queue_table (
    .clk(clk), .we(qt_we), .waddr(qt_waddr), .wdata(qt_wdata),
    .raddr(qt_raddr), .rdata(qt_rdata)
  );

  mqsb_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_slot_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );

  mqsb_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_slot_data (
    .clk(clk), .we(dt_we), .waddr(dt_waddr), .wdata(dt_wdata),
    .raddr(dt_raddr), .rdata(dt_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign q_head    = qt_rdata[SW +: LW];
  assign q_tail    = qt_rdata[SW-1:0];
  assign q_empty   = (q_head == LINK_NULL);
  assign free_null = (free_head_r == LINK_NULL);
  // Slots at or above the fill mark have never been handed out and still chain to s+1.
  assign fresh     = (free_head_r >= fill_r);
  assign next_free = fresh ? (free_head_r + LW'(1)) : lk_rdata;
  assign new_head  = (q_head[SW-1:0] == q_tail) ? LINK_NULL : lk_rdata;

  assign qt_raddr  = (state_r == S_IDLE) ? QW'(in_queue_id) : qaddr_r;

  always_comb begin
    lk_raddr = free_head_r[SW-1:0];
    dt_raddr = q_head[SW-1:0];
    if (((state_r == S_LOOK) && (kind_r == KIND_DEQ)) || (state_r == S_POP)) begin
      lk_raddr = q_head[SW-1:0];
    end
  end

  always_comb begin
    state_nxt           = state_r;
    clr_nxt             = clr_r;
    free_head_nxt       = free_head_r;
    fill_nxt            = fill_r;
    qt_we               = 1'b0;
    qt_waddr            = qaddr_r;
    qt_wdata            = qt_rdata;
    lk_we               = 1'b0;
    lk_waddr            = q_tail;
    lk_wdata            = free_head_r;
    dt_we               = 1'b0;
    dt_waddr            = free_head_r[SW-1:0];
    dt_wdata            = value_r;
    load                = 1'b0;
    out_read_value_nxt  = out_read_value_r;
    out_status_nxt      = out_status_r;
    out_queue_empty_nxt = out_queue_empty_r;
    out_buffer_full_nxt = out_buffer_full_r;

    case (state_r)
      S_CLEAR: begin
        qt_we    = 1'b1;
        qt_waddr = clr_r;
        qt_wdata = {LINK_NULL, SW'(0)};
        clr_nxt  = clr_r + QW'(1);
        if (clr_r == QW'(QUEUES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          if (kind_r == KIND_ENQ) begin
            load               = 1'b1;
            out_read_value_nxt = '0;
            state_nxt          = S_IDLE;
            if (!qvalid_r || free_null) begin
              out_status_nxt      = ST_OVERFLOW;
              out_queue_empty_nxt = !qvalid_r || q_empty;
              out_buffer_full_nxt = free_null;
            end else begin
              out_status_nxt      = ST_DONE;
              out_queue_empty_nxt = 1'b0;
              out_buffer_full_nxt = (next_free == LINK_NULL);
              free_head_nxt       = next_free;
              if (fresh) begin
                fill_nxt = fill_r + LW'(1);
              end
              qt_we    = 1'b1;
              qt_wdata = {(q_empty ? free_head_r : q_head), free_head_r[SW-1:0]};
              lk_we    = !q_empty;
              lk_waddr = q_tail;
              lk_wdata = free_head_r;
              dt_we    = 1'b1;
            end
          end else if (!qvalid_r || q_empty) begin
            load                = 1'b1;
            out_read_value_nxt  = '0;
            out_status_nxt      = ST_UNDERFLOW;
            out_queue_empty_nxt = 1'b1;
            out_buffer_full_nxt = free_null;
            state_nxt           = S_IDLE;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          load                = 1'b1;
          out_read_value_nxt  = VALUE_W'(dt_rdata);
          out_status_nxt      = ST_DONE;
          out_queue_empty_nxt = (new_head == LINK_NULL);
          out_buffer_full_nxt = 1'b0;
          qt_we               = 1'b1;
          qt_wdata            = {new_head, q_tail};
          lk_we               = 1'b1;
          lk_waddr            = q_head[SW-1:0];
          lk_wdata            = free_head_r;
          free_head_nxt       = q_head;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_head_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_kind;
      qvalid_r <= (int'(in_queue_id) < QUEUES);
      qaddr_r  <= QW'(in_queue_id);
      value_r  <= DW'(in_value);
    end
    out_read_value_r  <= out_read_value_nxt;
    out_status_r      <= out_status_nxt;
    out_queue_empty_r <= out_queue_empty_nxt;
    out_buffer_full_r <= out_buffer_full_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_status      = out_status_r;
  assign out_queue_empty = out_queue_empty_r;
  assign out_buffer_full = out_buffer_full_r;

endmodule

// File: sim/multi_queue_shared_buffer_tb.sv
// Self-checking testbench for multi_queue_shared_buffer: enqueue and dequeue requests,
// results predicted by a local model of the linked slots, free list and queue table.
// Depends on mqsb_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module multi_queue_shared_buffer_tb;
  import mqsb_pkg::*;

  localparam int SLOTS = 64;
  localparam int LANES = 8;
  localparam logic [6:0] NIL = 7'd64;
  localparam int RANDOM_REQS = 800;

  typedef enum logic [1:0] {
    PACE_RX_SLOW,
    PACE_TX_SLOW,
    PACE_FULL_RATE
  } pace_t;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic [QID_W-1:0]          qid;
    logic signed [VALUE_W-1:0] value;
    pace_t                     pace;
    logic                      drain;
    logic                      hold;
  } request_t;

  typedef struct {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic                      queue_empty;
    logic                      buffer_full;
  } result_t;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [KIND_W-1:0]           in_kind = KIND_ENQ;
  logic [QID_W-1:0]            in_queue_id = '0;
  logic signed [VALUE_W-1:0]   in_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [VALUE_W-1:0]   out_read_value;
  logic [STATUS_W-1:0]         out_status;
  logic                        out_queue_empty;
  logic                        out_buffer_full;

  request_t request_q[$];
  result_t  expected_q[$];
  request_t cur_req;
  pace_t    cur_pace = PACE_FULL_RATE;
  logic     hold_kick = 1'b0;
  logic     hold_seen = 1'b0;
  int       hold_left = 0;
  int       errors = 0;

  // Local copy of the buffer state.
  logic [6:0]         slot_next [0:SLOTS-1];
  logic [VALUE_W-1:0] slot_word [0:SLOTS-1];
  logic [6:0]         lane_head [0:LANES-1];
  logic [6:0]         lane_tail [0:LANES-1];
  logic [6:0]         free_top;

  multi_queue_shared_buffer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_queue_id    (in_queue_id),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_queue_empty(out_queue_empty),
    .out_buffer_full(out_buffer_full)
  );

  function automatic logic holds_slot(logic [6:0] s);
    return s < NIL;
  endfunction

  function automatic result_t buffer_step(request_t r);
    result_t    res;
    logic [6:0] s;
    int         q;
    q = int'(r.qid);
    res.read_value = '0;
    res.status = ST_DONE;
    if (r.kind == KIND_ENQ) begin
      if (!holds_slot(free_top)) begin
        res.status = ST_OVERFLOW;
      end else begin
        s = free_top;
        free_top = slot_next[s[5:0]];
        if (!holds_slot(lane_head[q])) begin
          lane_head[q] = s;
        end else if (holds_slot(lane_tail[q])) begin
          slot_next[lane_tail[q][5:0]] = s;
        end
        slot_next[s[5:0]] = NIL;
        lane_tail[q] = s;
        slot_word[s[5:0]] = r.value;
      end
    end else begin
      if (!holds_slot(lane_head[q])) begin
        res.status = ST_UNDERFLOW;
      end else begin
        s = lane_head[q];
        lane_head[q] = slot_next[s[5:0]];
        slot_next[s[5:0]] = free_top;
        free_top = s;
        res.read_value = slot_word[s[5:0]];
      end
    end
    res.queue_empty = !holds_slot(lane_head[q]);
    res.buffer_full = !holds_slot(free_top);
    return res;
  endfunction

  task automatic add_req(logic [KIND_W-1:0] kind, int qid, logic [VALUE_W-1:0] value,
                         pace_t pace, logic drain, logic hold);
    request_t r;
    r.kind = kind;
    r.qid = qid[QID_W-1:0];
    r.value = value;
    r.pace = pace;
    r.drain = drain;
    r.hold = hold;
    request_q.push_back(r);
  endtask

  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: presents queued requests, with gaps and a drain pause where flagged.
  always @(posedge clk) begin : driver
    request_t nxt;
    logic     take;
    int       gap;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(buffer_step(cur_req));
      end
      if (!in_valid || !in_stall) begin
        take = 1'b0;
        if (request_q.size() > 0) begin
          nxt = request_q[0];
          gap = (nxt.pace == PACE_RX_SLOW) ? 33 : (nxt.pace == PACE_TX_SLOW) ? 74 : 0;
          take = !(nxt.drain && expected_q.size() != 0) && ($urandom_range(0, 99) >= gap);
        end
        if (take) begin
          void'(request_q.pop_front());
          cur_req <= nxt;
          cur_pace <= nxt.pace;
          in_valid <= 1'b1;
          in_kind <= nxt.kind;
          in_queue_id <= nxt.qid;
          in_value <= nxt.value;
          if (nxt.hold) begin
            hold_kick <= ~hold_kick;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall, plus a long hold-off when the driver asks for one.
  always @(posedge clk) begin : receiver
    int gap;
    gap = (cur_pace == PACE_RX_SLOW) ? 74 : (cur_pace == PACE_TX_SLOW) ? 33 : 0;
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < gap);
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, read_value %h status %0d", $time,
                 out_read_value, out_status);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   out_read_value);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_queue_empty !== want.queue_empty) begin
          $display("%0t: queue_empty expected %b actual %b", $time, want.queue_empty,
                   out_queue_empty);
          errors++;
        end
        if (out_buffer_full !== want.buffer_full) begin
          $display("%0t: buffer_full expected %b actual %b", $time, want.buffer_full,
                   out_buffer_full);
          errors++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    pace_t pace;
    int    enq_pct;
    int    focus;
    int    lane;
    for (int i = 0; i < SLOTS; i++) begin
      slot_next[i] = 7'(i + 1);
      slot_word[i] = '0;
    end
    for (int i = 0; i < LANES; i++) begin
      lane_head[i] = NIL;
      lane_tail[i] = '0;
    end
    free_top = '0;

    // Directed: empty queue, extreme words, FIFO order, ignored dequeue value.
    add_req(KIND_DEQ, 0, 32'h0000_0000, PACE_FULL_RATE, 1'b0, 1'b0);
    add_req(KIND_ENQ, 0, 32'h8000_0000, PACE_FULL_RATE, 1'b0, 1'b0);
    add_req(KIND_ENQ, 0, 32'h7FFF_FFFF, PACE_FULL_RATE, 1'b0, 1'b0);
    add_req(KIND_ENQ, 0, 32'h0000_0000, PACE_FULL_RATE, 1'b0, 1'b0);
    add_req(KIND_ENQ, 0, 32'hFFFF_FFFF, PACE_FULL_RATE, 1'b0, 1'b0);
    add_req(KIND_ENQ, 7, 32'h5555_5555, PACE_FULL_RATE, 1'b0, 1'b0);
    add_req(KIND_ENQ, 7, 32'hAAAA_AAAA, PACE_FULL_RATE, 1'b0, 1'b0);
    for (int i = 0; i < 5; i++) begin
      add_req(KIND_DEQ, 0, 32'hFFFF_FFFF, PACE_FULL_RATE, 1'b0, 1'b0);
    end
    for (int i = 0; i < 3; i++) begin
      add_req(KIND_DEQ, 7, 32'hFFFF_FFFF, PACE_FULL_RATE, 1'b0, 1'b0);
    end
    add_req(KIND_ENQ, 3, 32'h1234_5678, PACE_FULL_RATE, 1'b0, 1'b0);
    add_req(KIND_ENQ, 5, 32'hDEAD_BEEF, PACE_FULL_RATE, 1'b0, 1'b0);
    add_req(KIND_DEQ, 3, 32'h0000_0000, PACE_FULL_RATE, 1'b0, 1'b0);
    add_req(KIND_DEQ, 5, 32'h0000_0000, PACE_FULL_RATE, 1'b0, 1'b0);

    // Random: segments with their own enqueue mix and queue spread, the first one
    // filling the buffer past full.
    enq_pct = 95;
    focus = -1;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i >= 80 && i % 40 == 0) begin
        enq_pct = $urandom_range(5, 95);
        focus = ($urandom_range(0, 2) == 0) ? $urandom_range(0, LANES - 1) : -1;
      end
      pace = (i < 260) ? PACE_RX_SLOW : (i < 530) ? PACE_TX_SLOW : PACE_FULL_RATE;
      lane = (focus < 0) ? $urandom_range(0, LANES - 1) : (focus + $urandom_range(0, 1)) % LANES;
      add_req(($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ, lane, pick_word(),
              pace, (i == 300 || i == 530 || i == 700), (i == 20 || i == 600));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mqsb_pkg.sv
rtl/mqsb_ram.sv
rtl/multi_queue_shared_buffer.sv
sim/multi_queue_shared_buffer_tb.sv
